### rtl/dnpa_pkg.sv
// Shared types and constants of the duo note priority allocator.
// Used by dnpa_stack, dnpa_ctrl and the top level; depends on nothing.
`default_nettype none

package dnpa_pkg;

    // note number width and target code for an empty stack
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned TARGET_W = 8;
    localparam logic [TARGET_W-1:0] NOTE_OFF = 8'hFF;

    // key event kinds carried on the input tuser
    localparam logic ACT_NOTE_ON  = 1'b0;
    localparam logic ACT_NOTE_OFF = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_ON = 1'b1;

    // key mode values
    localparam logic MODE_MONO = 1'b0;
    localparam logic MODE_DUO  = 1'b1;

    // stack operations issued by the controller
    typedef enum logic [1:0] {
        OP_NOP,
        OP_REMOVE,  // compact, skipping the first entry equal to the note
        OP_DROP,    // compact, skipping the oldest entry
        OP_APPEND   // write the note as the newest entry
    } t_stk_op;

    typedef struct packed {
        t_stk_op           op;
        logic [NOTE_W-1:0] note;
    } t_stk_cmd;

    typedef struct packed {
        logic              busy;
        logic              empty;
        logic              single;
        logic              full;
        logic [NOTE_W-1:0] top;
    } t_stk_stat;

endpackage

`default_nettype wire

### rtl/dnpa_stack.sv
// One last-note-priority stack: entry memory, fill count, cached top entry and
// the compaction walker for removals. Depends on dnpa_pkg.
`default_nettype none

module dnpa_stack #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dnpa_pkg::t_stk_cmd  i_cmd,
    output dnpa_pkg::t_stk_stat o_stat
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(STACK_DEPTH);
    localparam logic [FW-1:0] FILL_ONE = FW'(1);

    logic [dnpa_pkg::NOTE_W-1:0] r_mem [STACK_DEPTH];
    logic [dnpa_pkg::NOTE_W-1:0] r_rd_data;
    logic [dnpa_pkg::NOTE_W-1:0] r_note;
    logic [dnpa_pkg::NOTE_W-1:0] r_top;
    logic [FW-1:0]               r_fill;
    logic [FW-1:0]               r_rd_idx;
    logic [AW-1:0]               r_wr_idx;
    logic                        r_busy;
    logic                        r_pend;
    logic                        r_pend_first;
    logic                        r_found;
    logic                        r_mode_drop;

    logic                        rd_en;
    logic                        skip;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [dnpa_pkg::NOTE_W-1:0] wr_data;
    logic                        append;

    // read the next entry while entries remain
    assign rd_en  = r_busy && (r_rd_idx < r_fill);
    assign append = (i_cmd.op == dnpa_pkg::OP_APPEND);

    // drop the oldest entry, or the first match of the note
    assign skip = r_mode_drop ? r_pend_first
                              : (!r_found && (r_rd_data == r_note));

    // single write port: append or compaction write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_idx;
        wr_data = r_rd_data;
        if (append) begin
            wr_en   = 1'b1;
            wr_addr = r_fill[AW-1:0];
            wr_data = i_cmd.note;
        end else if (r_pend && !skip) begin
            wr_en = 1'b1;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    // walker and fill control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_fill <= '0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd.op == dnpa_pkg::OP_REMOVE || i_cmd.op == dnpa_pkg::OP_DROP) begin
                r_busy <= 1'b1;
            end else if (append) begin
                r_fill <= r_fill + FILL_ONE;
            end else if (r_busy && !rd_en && !r_pend) begin
                r_busy <= 1'b0;
                r_fill <= r_fill - {{(FW-1){1'b0}}, r_found};
            end
        end
    end

    // walker payload: indexes, match flag and cached top
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dnpa_pkg::OP_REMOVE || i_cmd.op == dnpa_pkg::OP_DROP) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_found     <= 1'b0;
            r_mode_drop <= (i_cmd.op == dnpa_pkg::OP_DROP);
            r_note      <= i_cmd.note;
        end else begin
            if (rd_en) begin
                r_rd_idx     <= r_rd_idx + FILL_ONE;
                r_pend_first <= (r_rd_idx == '0);
            end
            if (r_pend) begin
                if (skip) begin
                    r_found <= 1'b1;
                end else begin
                    r_wr_idx <= r_wr_idx + AW'(1);
                    r_top    <= r_rd_data;
                end
            end
        end
        if (append) begin
            r_top <= i_cmd.note;
        end
    end

    assign o_stat.busy   = r_busy;
    assign o_stat.empty  = (r_fill == '0);
    assign o_stat.single = (r_fill == FILL_ONE);
    assign o_stat.full   = (r_fill == FILL_MAX);
    assign o_stat.top    = r_top;

endmodule

`default_nettype wire

### rtl/dnpa_ctrl.sv
// Controller of the allocator: configuration registers, key event sequencing,
// stack selection and the result register. Depends on dnpa_pkg.
`default_nettype none

module dnpa_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    input  wire [dnpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire                              i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_in_action,
    input  wire [dnpa_pkg::NOTE_W-1:0]       i_in_note,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [dnpa_pkg::TARGET_W-1:0]    o_low_note,
    output logic [dnpa_pkg::TARGET_W-1:0]    o_high_note,
    output logic                             o_start_envelope,
    output logic                             o_stop_envelope,
    output dnpa_pkg::t_stk_cmd               o_cmd_lo,
    output dnpa_pkg::t_stk_cmd               o_cmd_hi,
    input  dnpa_pkg::t_stk_stat              i_stat_lo,
    input  dnpa_pkg::t_stk_stat              i_stat_hi
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM,
        S_REM_W,
        S_DROP,
        S_DROP_W,
        S_APP,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic                        r_key_mode;
    logic                        r_glide_on;
    logic                        r_action;
    logic                        r_sel_lo;
    logic                        r_sel_hi;

    logic [dnpa_pkg::TARGET_W-1:0] lo_t;
    logic [dnpa_pkg::TARGET_W-1:0] hi_t;
    logic [dnpa_pkg::TARGET_W-1:0] n_t;
    logic                          sel_lo;
    logic                          sel_hi;
    logic                          stacks_idle;

    // current targets, empty stack reads as off
    assign lo_t = i_stat_lo.empty ? dnpa_pkg::NOTE_OFF : {1'b0, i_stat_lo.top};
    assign hi_t = i_stat_hi.empty ? dnpa_pkg::NOTE_OFF : {1'b0, i_stat_hi.top};
    assign n_t  = {1'b0, i_in_note};

    assign stacks_idle = !i_stat_lo.busy && !i_stat_hi.busy;
    assign o_in_ready  = (r_state == S_IDLE);

    // pick the stacks a note on goes to
    always_comb begin
        sel_lo = 1'b1;
        sel_hi = 1'b1;
        if (i_in_action == dnpa_pkg::ACT_NOTE_ON && r_key_mode == dnpa_pkg::MODE_DUO &&
            !(i_stat_lo.empty && i_stat_hi.empty)) begin
            if (n_t < lo_t) begin
                sel_hi = 1'b0;
            end else if (n_t > hi_t) begin
                sel_lo = 1'b0;
            end else if ((n_t - lo_t) < (hi_t - n_t)) begin
                sel_hi = 1'b0;
            end else begin
                sel_lo = 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= dnpa_pkg::MODE_MONO;
            r_glide_on <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dnpa_pkg::CFG_KEY_MODE: r_key_mode <= i_cfg_data;
                dnpa_pkg::CFG_GLIDE_ON: r_glide_on <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // event latch
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_in_action;
            r_sel_lo <= sel_lo;
            r_sel_hi <= sel_hi;
        end
    end

    // sequencer with registered commands and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            o_cmd_lo.op    <= dnpa_pkg::OP_NOP;
            o_cmd_hi.op    <= dnpa_pkg::OP_NOP;
            o_out_valid    <= 1'b0;
        end else begin
            // release the result once taken, unless a new one is loaded now
            if (o_out_valid && i_out_ready && r_state != S_FIN) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd_lo.op   <= sel_lo ? dnpa_pkg::OP_REMOVE : dnpa_pkg::OP_NOP;
                        o_cmd_hi.op   <= sel_hi ? dnpa_pkg::OP_REMOVE : dnpa_pkg::OP_NOP;
                        o_cmd_lo.note <= i_in_note;
                        o_cmd_hi.note <= i_in_note;
                        r_state       <= S_REM;
                    end
                end
                S_REM: begin
                    o_cmd_lo.op <= dnpa_pkg::OP_NOP;
                    o_cmd_hi.op <= dnpa_pkg::OP_NOP;
                    r_state     <= S_REM_W;
                end
                S_REM_W: begin
                    if (stacks_idle) begin
                        if (r_action == dnpa_pkg::ACT_NOTE_ON) begin
                            if ((r_sel_lo && i_stat_lo.full) || (r_sel_hi && i_stat_hi.full)) begin
                                o_cmd_lo.op <= (r_sel_lo && i_stat_lo.full) ?
                                               dnpa_pkg::OP_DROP : dnpa_pkg::OP_NOP;
                                o_cmd_hi.op <= (r_sel_hi && i_stat_hi.full) ?
                                               dnpa_pkg::OP_DROP : dnpa_pkg::OP_NOP;
                                r_state     <= S_DROP;
                            end else begin
                                o_cmd_lo.op <= r_sel_lo ? dnpa_pkg::OP_APPEND : dnpa_pkg::OP_NOP;
                                o_cmd_hi.op <= r_sel_hi ? dnpa_pkg::OP_APPEND : dnpa_pkg::OP_NOP;
                                r_state     <= S_APP;
                            end
                        end else begin
                            // refill an emptied stack from the other one's top
                            o_cmd_lo.note <= i_stat_hi.top;
                            o_cmd_hi.note <= i_stat_lo.top;
                            o_cmd_lo.op   <= (i_stat_lo.empty && !i_stat_hi.empty) ?
                                             dnpa_pkg::OP_APPEND : dnpa_pkg::OP_NOP;
                            o_cmd_hi.op   <= (!i_stat_lo.empty && i_stat_hi.empty) ?
                                             dnpa_pkg::OP_APPEND : dnpa_pkg::OP_NOP;
                            r_state       <= S_APP;
                        end
                    end
                end
                S_DROP: begin
                    o_cmd_lo.op <= dnpa_pkg::OP_NOP;
                    o_cmd_hi.op <= dnpa_pkg::OP_NOP;
                    r_state     <= S_DROP_W;
                end
                S_DROP_W: begin
                    if (stacks_idle) begin
                        o_cmd_lo.op <= r_sel_lo ? dnpa_pkg::OP_APPEND : dnpa_pkg::OP_NOP;
                        o_cmd_hi.op <= r_sel_hi ? dnpa_pkg::OP_APPEND : dnpa_pkg::OP_NOP;
                        r_state     <= S_APP;
                    end
                end
                S_APP: begin
                    o_cmd_lo.op <= dnpa_pkg::OP_NOP;
                    o_cmd_hi.op <= dnpa_pkg::OP_NOP;
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    // load the result once the output register is free
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid      <= 1'b1;
                        o_low_note       <= lo_t;
                        o_high_note      <= hi_t;
                        o_start_envelope <= (r_action == dnpa_pkg::ACT_NOTE_ON) &&
                                            ((i_stat_lo.single && i_stat_hi.single) ||
                                             !r_glide_on);
                        o_stop_envelope  <= (r_action == dnpa_pkg::ACT_NOTE_OFF) &&
                                            i_stat_lo.empty && i_stat_hi.empty;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a new item is only taken with both stacks quiet
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> stacks_idle)
        else $error("item accepted while a stack walk runs");

    // no command reaches a stack in the middle of its walk
    a_cmd_lo_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_lo.op != dnpa_pkg::OP_NOP) |-> !i_stat_lo.busy)
        else $error("low stack command while busy");

    a_cmd_hi_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_hi.op != dnpa_pkg::OP_NOP) |-> !i_stat_hi.busy)
        else $error("high stack command while busy");

    // appends never overflow a stack
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((o_cmd_lo.op == dnpa_pkg::OP_APPEND) && i_stat_lo.full) &&
        !((o_cmd_hi.op == dnpa_pkg::OP_APPEND) && i_stat_hi.full))
        else $error("append into a full stack");

    // start and stop never come together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_start_envelope && o_stop_envelope))
        else $error("start and stop flags both set");

endmodule

`default_nettype wire

### rtl/duo_note_priority_allocator.sv
// Top level of the duo note priority allocator: controller plus low and high
// note stacks. Depends on dnpa_pkg, dnpa_ctrl and dnpa_stack.
//
// Usage:
//   Input stream s_axis: tdata[6:0] note number, tuser[0] 0 note on / 1 note off.
//   Output stream m_axis: one item per key event with the low and high targets
//   (255 when a stack is empty) and the envelope start and stop flags.
//   Config channel i_cfg_*: index 0 key mode (0 mono, 1 duo), index 1 glide on;
//   always ready, write only while no key event is in flight.
// Timing:
//   One key event is worked on at a time. Each stack removal is a walk over the
//   stored entries through the stack memory's single read port. A note on into
//   a full stack adds a second walk that drops the oldest entry. The next event
//   can be taken in the cycle after the result is loaded.
// Reset: both stacks empty, mono mode, glide off; no clearing pass.
// Stalls: a finished result waits in the output register while the next event
//   is taken and worked on; that event's result holds until the first is taken.
`default_nettype none

module duo_note_priority_allocator #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration writes
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [dnpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire                            i_cfg_data,
    // key events
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [7:0]                      s_axis_tdata,   // [6:0] note, [7] zero
    input  wire [0:0]                      s_axis_tuser,   // [0] action
    // results
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [23:0]                    m_axis_tdata    // [7:0] low_note,
                                                           // [15:8] high_note,
                                                           // [16] start_envelope,
                                                           // [17] stop_envelope,
                                                           // [23:18] zero
);

    dnpa_pkg::t_stk_cmd  cmd_lo;
    dnpa_pkg::t_stk_cmd  cmd_hi;
    dnpa_pkg::t_stk_stat stat_lo;
    dnpa_pkg::t_stk_stat stat_hi;

    logic [dnpa_pkg::TARGET_W-1:0] low_note;
    logic [dnpa_pkg::TARGET_W-1:0] high_note;
    logic                          start_envelope;
    logic                          stop_envelope;

    assign o_cfg_ready = 1'b1;

    dnpa_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_in_action      (s_axis_tuser[0]),
        .i_in_note        (s_axis_tdata[dnpa_pkg::NOTE_W-1:0]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_low_note       (low_note),
        .o_high_note      (high_note),
        .o_start_envelope (start_envelope),
        .o_stop_envelope  (stop_envelope),
        .o_cmd_lo         (cmd_lo),
        .o_cmd_hi         (cmd_hi),
        .i_stat_lo        (stat_lo),
        .i_stat_hi        (stat_hi)
    );

    dnpa_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_lo),
        .o_stat  (stat_lo)
    );

    dnpa_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_hi),
        .o_stat  (stat_hi)
    );

    // pack the result item
    assign m_axis_tdata = {6'd0, stop_envelope, start_envelope, high_note, low_note};

endmodule

`default_nettype wire
